// ===== sv/kl_pkg.sv =====
// Shared types, constants and helper functions of the keyword lexer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package kl_pkg;

  localparam int NumberWidth = 32;
  localparam int PosWidth    = 16;
  localparam int QueueDepth  = 4;

  localparam logic [7:0] MaxIdent = 8'd254;

  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChCr  = 8'h0D;

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_EOL  = 2'd1,
    OP_EOI  = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    KIND_LET      = 5'd0,
    KIND_NUMBER   = 5'd1,
    KIND_PLUS     = 5'd2,
    KIND_MINUS    = 5'd3,
    KIND_STAR     = 5'd4,
    KIND_DIVIDE   = 5'd5,
    KIND_ASSIGN   = 5'd6,
    KIND_LPAREN   = 5'd7,
    KIND_RPAREN   = 5'd8,
    KIND_LBRACE   = 5'd9,
    KIND_RBRACE   = 5'd10,
    KIND_COMMA    = 5'd11,
    KIND_COLON    = 5'd12,
    KIND_SEMI     = 5'd13,
    KIND_RETURN   = 5'd14,
    KIND_IDENT    = 5'd15,
    KIND_FUNCTION = 5'd16,
    KIND_EOF      = 5'd17,
    KIND_UNKNOWN  = 5'd18
  } token_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_KEYWORD = 3'd1,
    MODE_SLASH   = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_NUMBER  = 3'd4,
    MODE_IDENT   = 3'd5
  } lex_mode_e;

  typedef enum logic [1:0] {
    KW_LET      = 2'd0,
    KW_RETURN   = 2'd1,
    KW_FUNCTION = 2'd2
  } kw_cand_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
  } lex_item_t;

  typedef struct packed {
    token_kind_e               token_kind;
    logic [NumberWidth-1:0]    number_value;
    logic [PosWidth-1:0]       ident_line;
    logic [PosWidth-1:0]       ident_column;
    logic [7:0]                ident_length;
    logic                      ident_too_long;
    logic                      last;
  } lex_token_t;

  // All tokens caused by one input item; tok1 is meaningful only when two is set.
  typedef struct packed {
    lex_token_t tok0;
    lex_token_t tok1;
    logic       two;
  } lex_bundle_t;

  function automatic lex_token_t make_token(token_kind_e kind,
                                            logic [NumberWidth-1:0] num,
                                            logic [PosWidth-1:0] line,
                                            logic [PosWidth-1:0] col,
                                            logic [7:0] len,
                                            logic over);
    lex_token_t t;
    t.token_kind     = kind;
    t.number_value   = num;
    t.ident_line     = line;
    t.ident_column   = col;
    t.ident_length   = len;
    t.ident_too_long = over;
    t.last           = 1'b0;
    return t;
  endfunction

  function automatic lex_token_t plain_token(token_kind_e kind);
    return make_token(kind, '0, '0, '0, 8'd0, 1'b0);
  endfunction

  function automatic logic [3:0] kw_len(kw_cand_e cand);
    logic [3:0] len;
    unique case (cand)
      KW_LET:      len = 4'd3;
      KW_RETURN:   len = 4'd6;
      KW_FUNCTION: len = 4'd8;
      default:     len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic token_kind_e kw_kind(kw_cand_e cand);
    token_kind_e kind;
    unique case (cand)
      KW_LET:      kind = KIND_LET;
      KW_RETURN:   kind = KIND_RETURN;
      KW_FUNCTION: kind = KIND_FUNCTION;
      default:     kind = KIND_UNKNOWN;
    endcase
    return kind;
  endfunction

  // Character of the keyword at position idx; the first character sits in the top byte.
  function automatic logic [7:0] kw_char(kw_cand_e cand, logic [3:0] idx);
    logic [63:0] text;
    logic [63:0] shifted;
    unique case (cand)
      KW_LET:      text = {"let", 40'h0};
      KW_RETURN:   text = {"return", 16'h0};
      KW_FUNCTION: text = "function";
      default:     text = '0;
    endcase
    shifted = text << {idx[2:0], 3'b000};
    return shifted[63:56];
  endfunction

  function automatic token_kind_e symbol_kind(logic [7:0] c);
    token_kind_e kind;
    unique case (c)
      "+":     kind = KIND_PLUS;
      "-":     kind = KIND_MINUS;
      "*":     kind = KIND_STAR;
      "=":     kind = KIND_ASSIGN;
      "(":     kind = KIND_LPAREN;
      ")":     kind = KIND_RPAREN;
      "{":     kind = KIND_LBRACE;
      "}":     kind = KIND_RBRACE;
      ",":     kind = KIND_COMMA;
      ":":     kind = KIND_COLON;
      ";":     kind = KIND_SEMI;
      default: kind = KIND_UNKNOWN;
    endcase
    return kind;
  endfunction

endpackage

`default_nettype wire

// ===== sv/kl_front.sv =====
// Front end of the keyword lexer: the lexer state machine that classifies each
// input item and bundles the tokens it causes. Depends on kl_pkg.
`default_nettype none

module kl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  kl_pkg::lex_item_t   item_i,
  output kl_pkg::lex_bundle_t bundle_o,
  output logic                bundle_valid_o
);
  import kl_pkg::*;

  lex_mode_e              mode_q, mode_d;
  kw_cand_e               cand_q, cand_d;
  logic [3:0]             match_q, match_d;
  logic [NumberWidth-1:0] acc_q, acc_d;
  logic [PosWidth-1:0]    line_q, line_d;
  logic [PosWidth-1:0]    col_q, col_d;
  logic [PosWidth-1:0]    start_q, start_d;
  logic [7:0]             icount_q, icount_d;
  logic                   over_q, over_d;

  logic                   is_char, is_eol, is_eoi;
  logic [7:0]             c;
  logic                   is_blank, is_letter, is_digit, is_word, is_slash, is_kwstart;
  logic                   kw_hit, kw_done, tok_end, fresh, fresh_sym;
  logic [NumberWidth-1:0] acc_next;
  logic                   flush_v;
  lex_token_t             flush_tok;
  logic                   a_v, b_v;
  lex_token_t             tok_a, tok_b;

  assign c = item_i.ch;

  always_comb begin
    is_char = 1'b0;
    is_eol  = 1'b0;
    is_eoi  = 1'b0;
    unique case (item_i.op)
      OP_CHAR: is_char = 1'b1;
      OP_EOL:  is_eol  = 1'b1;
      OP_EOI:  is_eoi  = 1'b1;
      default: ;
    endcase
  end

  assign is_blank   = (c == " ") || (c == ChTab) || (c == ChLf) || (c == ChCr);
  assign is_letter  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign is_digit   = (c >= "0") && (c <= "9");
  assign is_word    = is_letter || is_digit || (c == "_");
  assign is_slash   = (c == "/");
  assign is_kwstart = (c == "l") || (c == "r") || (c == "f");

  assign kw_hit  = (match_q < kw_len(cand_q)) && (c == kw_char(cand_q, match_q));
  assign kw_done = (match_q + 4'd1) >= kw_len(cand_q);

  // Multiply by ten as two shifts and an add, then add the new digit.
  assign acc_next = (acc_q << 3) + (acc_q << 1) + NumberWidth'(c[3:0]);

  always_comb begin
    tok_end = 1'b0;
    unique case (mode_q)
      MODE_KEYWORD: tok_end = !kw_hit && !is_word;
      MODE_IDENT:   tok_end = !is_word;
      MODE_NUMBER:  tok_end = !is_digit;
      MODE_SLASH:   tok_end = !is_slash;
      default:      tok_end = 1'b0;
    endcase
  end

  // A byte that ends a token is lexed again from the idle state.
  assign fresh     = is_char && ((mode_q == MODE_IDLE) || tok_end);
  assign fresh_sym = !is_blank && !is_kwstart && !is_slash && !is_letter && !is_digit;

  // Token that is pending in the current mode, emitted when something ends it.
  always_comb begin
    flush_v   = 1'b1;
    flush_tok = plain_token(KIND_DIVIDE);
    unique case (mode_q)
      MODE_KEYWORD: flush_tok = make_token(KIND_IDENT, '0, line_q, start_q,
                                           {4'b0000, match_q}, 1'b0);
      MODE_IDENT:   flush_tok = make_token(KIND_IDENT, '0, line_q, start_q,
                                           icount_q, over_q);
      MODE_NUMBER:  flush_tok = make_token(KIND_NUMBER, acc_q, '0, '0, 8'd0, 1'b0);
      MODE_SLASH:   flush_tok = plain_token(KIND_DIVIDE);
      default:      flush_v   = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    mode_d   = mode_q;
    cand_d   = cand_q;
    match_d  = match_q;
    acc_d    = acc_q;
    line_d   = line_q;
    col_d    = col_q;
    start_d  = start_q;
    icount_d = icount_q;
    over_d   = over_q;
    if (accept_i) begin
      if (is_char) begin
        col_d = col_q + PosWidth'(1);
        unique case (mode_q)
          MODE_KEYWORD: begin
            if (kw_hit) begin
              match_d = match_q + 4'd1;
              if (kw_done) begin
                mode_d = MODE_IDLE;
              end
            end else if (is_word) begin
              // Partial keyword turns into an identifier that keeps growing.
              mode_d   = MODE_IDENT;
              icount_d = {4'b0000, match_q} + 8'd1;
              over_d   = 1'b0;
            end
          end
          MODE_IDENT: begin
            if (is_word) begin
              if (icount_q < MaxIdent) begin
                icount_d = icount_q + 8'd1;
              end else begin
                over_d = 1'b1;
              end
            end
          end
          MODE_NUMBER: begin
            if (is_digit) begin
              acc_d = acc_next;
            end
          end
          MODE_SLASH: begin
            if (is_slash) begin
              mode_d = MODE_COMMENT;
            end
          end
          MODE_COMMENT: begin
            if (c == ChLf) begin
              mode_d = MODE_IDLE;
            end
          end
          default: ;
        endcase
        if (fresh) begin
          mode_d = MODE_IDLE;
          if (is_kwstart) begin
            mode_d  = MODE_KEYWORD;
            cand_d  = (c == "l") ? KW_LET : ((c == "r") ? KW_RETURN : KW_FUNCTION);
            match_d = 4'd1;
            start_d = col_q;
          end else if (is_slash) begin
            mode_d = MODE_SLASH;
          end else if (is_letter) begin
            mode_d   = MODE_IDENT;
            icount_d = 8'd1;
            over_d   = 1'b0;
            start_d  = col_q;
          end else if (is_digit) begin
            mode_d = MODE_NUMBER;
            acc_d  = NumberWidth'(c[3:0]);
          end
        end
      end else if (is_eol) begin
        mode_d = MODE_IDLE;
        line_d = line_q + PosWidth'(1);
        col_d  = '0;
      end else if (is_eoi) begin
        mode_d = MODE_IDLE;
        line_d = '0;
        col_d  = '0;
      end
    end
  end

  // Tokens: at most one that closes the current token, then at most one more.
  always_comb begin
    a_v   = 1'b0;
    tok_a = flush_tok;
    b_v   = 1'b0;
    tok_b = plain_token(symbol_kind(c));
    if (is_char) begin
      if ((mode_q == MODE_KEYWORD) && kw_hit && kw_done) begin
        a_v   = 1'b1;
        tok_a = plain_token(kw_kind(cand_q));
      end else if (tok_end) begin
        a_v = flush_v;
      end
      b_v = fresh && fresh_sym;
    end else if (is_eol) begin
      a_v = flush_v;
    end else if (is_eoi) begin
      a_v   = flush_v;
      b_v   = 1'b1;
      tok_b = plain_token(KIND_EOF);
    end
  end

  always_comb begin
    bundle_o.two       = a_v && b_v;
    bundle_o.tok0      = a_v ? tok_a : tok_b;
    bundle_o.tok0.last = !(a_v && b_v);
    bundle_o.tok1      = tok_b;
    bundle_o.tok1.last = 1'b1;
  end

  assign bundle_valid_o = accept_i && (a_v || b_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      cand_q   <= KW_LET;
      match_q  <= 4'd0;
      acc_q    <= '0;
      line_q   <= '0;
      col_q    <= '0;
      start_q  <= '0;
      icount_q <= 8'd0;
      over_q   <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      cand_q   <= cand_d;
      match_q  <= match_d;
      acc_q    <= acc_d;
      line_q   <= line_d;
      col_q    <= col_d;
      start_q  <= start_d;
      icount_q <= icount_d;
      over_q   <= over_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/kl_queue.sv =====
// Bundle queue between the lexer front end and the token output stage.
// Depends on kl_pkg for the bundle type.
`default_nettype none

module kl_queue #(
  parameter int Depth = kl_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  kl_pkg::lex_bundle_t wr_data_i,
  output logic                full_o,
  input  logic                rd_en_i,
  output kl_pkg::lex_bundle_t rd_data_o,
  output logic                rd_valid_o
);
  import kl_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  lex_bundle_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({wr_en_i, rd_en_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/kl_back.sv =====
// Token output stage: presents the tokens of the oldest queued bundle one per
// transfer and releases the bundle after its last token. Depends on kl_pkg.
`default_nettype none

module kl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kl_pkg::lex_bundle_t head_i,
  input  logic                head_valid_i,
  output logic                head_release_o,
  input  logic                pop,
  output logic                empty,
  output kl_pkg::lex_token_t  token_o
);
  import kl_pkg::*;

  logic sel_q, sel_d;
  logic take;

  assign empty   = !head_valid_i;
  assign token_o = sel_q ? head_i.tok1 : head_i.tok0;
  assign take    = pop && head_valid_i;

  // The bundle leaves the queue once its final token is transferred.
  assign head_release_o = take && (sel_q || !head_i.two);

  always_comb begin
    sel_d = sel_q;
    if (take) begin
      sel_d = !sel_q && head_i.two;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/keyword_lexer.sv =====
// Top level of the keyword lexer: front end, bundle queue and output stage.
// Depends on kl_pkg, kl_front, kl_queue and kl_back.
//
// Usage: the source stream enters as items on item_i (op: character, end of
// line or end of input; ch: the byte). An item is transferred at a clock edge
// with push high and full low. Tokens leave on token_o in order; a token is
// valid while empty is low and is transferred at an edge with pop high.
// The tokens caused by an item are registered in the queue at the item's
// transfer and visible once their bundle reaches the queue head. Throughput:
// one item per cycle while full is low. Each item causes zero, one or two
// tokens, kept together in one queue entry, so a two-token item needs two pops.
// Stalls: when the receiver stops popping, up to QueueDepth items that cause
// tokens are buffered; full then rises until a bundle is drained. While full
// is high no item is accepted, including one that would cause no token.
// Reset: an asynchronous low rst_ni empties the queue, returns the lexer to
// idle and sets the line and column counters to zero.
`default_nettype none

module keyword_lexer #(
  parameter int QueueDepth = kl_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  kl_pkg::lex_item_t  item_i,
  output logic               empty,
  input  logic               pop,
  output kl_pkg::lex_token_t token_o
);
  import kl_pkg::*;

  logic        accept;
  lex_bundle_t bundle;
  logic        bundle_valid;
  lex_bundle_t head;
  logic        head_valid;
  logic        head_release;

  assign accept = push && !full;

  kl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .item_i         (item_i),
    .bundle_o       (bundle),
    .bundle_valid_o (bundle_valid)
  );

  kl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (bundle_valid),
    .wr_data_i  (bundle),
    .full_o     (full),
    .rd_en_i    (head_release),
    .rd_data_o  (head),
    .rd_valid_o (head_valid)
  );

  kl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .head_release_o (head_release),
    .pop            (pop),
    .empty          (empty),
    .token_o        (token_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_keyword_lexer.sv =====
// Self-checking testbench for keyword_lexer: drives byte and marker items through
// the queue-style handshake and checks every token against an in-bench tokenizer.
// Depends on kl_pkg and keyword_lexer.

module tb_keyword_lexer;
  import kl_pkg::*;

  localparam int LongHold      = 150;
  localparam int WatchdogLimit = 1000;
  localparam int TailCycles    = 10;
  localparam int RandomItems   = 50;
  localparam logic [1:0] OpUnused = 2'd3;

  // Tracks the tokenizer state and holds the tokens still owed by the block.
  class token_scoreboard;
    lex_mode_e              mode;
    kw_cand_e               cand;
    logic [3:0]             matched;
    logic [NumberWidth-1:0] number_acc;
    logic [PosWidth-1:0]    line_no;
    logic [PosWidth-1:0]    col_no;
    logic [PosWidth-1:0]    start_col;
    logic [7:0]             ident_len;
    logic                   ident_over;
    string                  keyword_text [3];
    token_kind_e            keyword_kind [3];
    lex_token_t             step_tokens [$];
    lex_token_t             expected_tokens [$];
    int                     errors;
    int                     tokens_checked;

    function new();
      keyword_text[0] = "let";
      keyword_text[1] = "return";
      keyword_text[2] = "function";
      keyword_kind[0] = KIND_LET;
      keyword_kind[1] = KIND_RETURN;
      keyword_kind[2] = KIND_FUNCTION;
      mode = MODE_IDLE;
      cand = KW_LET;
      matched = '0;
      number_acc = '0;
      line_no = '0;
      col_no = '0;
      start_col = '0;
      ident_len = '0;
      ident_over = 1'b0;
      errors = 0;
      tokens_checked = 0;
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    function void add_token(token_kind_e kind, logic [NumberWidth-1:0] num,
                            logic [PosWidth-1:0] ln, logic [PosWidth-1:0] col,
                            logic [7:0] len, logic over);
      lex_token_t t;
      t.token_kind     = kind;
      t.number_value   = num;
      t.ident_line     = ln;
      t.ident_column   = col;
      t.ident_length   = len;
      t.ident_too_long = over;
      t.last           = 1'b0;
      step_tokens.push_back(t);
    endfunction

    function void add_plain(token_kind_e kind);
      add_token(kind, '0, '0, '0, '0, 1'b0);
    endfunction

    function void add_ident();
      add_token(KIND_IDENT, '0, line_no, start_col, ident_len, ident_over);
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function token_kind_e symbol_token(logic [7:0] c);
      case (c)
        "+":     return KIND_PLUS;
        "-":     return KIND_MINUS;
        "*":     return KIND_STAR;
        "=":     return KIND_ASSIGN;
        "(":     return KIND_LPAREN;
        ")":     return KIND_RPAREN;
        "{":     return KIND_LBRACE;
        "}":     return KIND_RBRACE;
        ",":     return KIND_COMMA;
        ":":     return KIND_COLON;
        ";":     return KIND_SEMI;
        default: return KIND_UNKNOWN;
      endcase
    endfunction

    // A byte seen with nothing pending decides which token kind starts here.
    function void begin_token(logic [7:0] c, logic [PosWidth-1:0] col);
      mode = MODE_IDLE;
      if (c == " " || c == ChTab || c == ChLf || c == ChCr) return;
      if (c == "l" || c == "r" || c == "f") begin
        mode = MODE_KEYWORD;
        cand = (c == "l") ? KW_LET : ((c == "r") ? KW_RETURN : KW_FUNCTION);
        matched = 4'd1;
        start_col = col;
      end else if (c == "/") begin
        mode = MODE_SLASH;
      end else if (is_letter(c)) begin
        mode = MODE_IDENT;
        ident_len = 8'd1;
        ident_over = 1'b0;
        start_col = col;
      end else if (is_digit(c)) begin
        mode = MODE_NUMBER;
        number_acc = NumberWidth'(c - "0");
      end else begin
        add_plain(symbol_token(c));
      end
    endfunction

    function void continue_ident(logic [7:0] c, logic [PosWidth-1:0] col);
      if (is_letter(c) || is_digit(c) || c == "_") begin
        if (ident_len < MaxIdent) ident_len = ident_len + 8'd1;
        else ident_over = 1'b1;
      end else begin
        add_ident();
        begin_token(c, col);
      end
    endfunction

    function void feed(logic [7:0] c, logic [PosWidth-1:0] col);
      int idx;
      idx = int'(cand);
      case (mode)
        MODE_KEYWORD: begin
          if (matched < keyword_text[idx].len() && c == keyword_text[idx][matched]) begin
            matched = matched + 4'd1;
            if (matched >= keyword_text[idx].len()) begin
              add_plain(keyword_kind[idx]);
              mode = MODE_IDLE;
            end
          end else begin
            // A broken keyword prefix carries on as an identifier.
            mode = MODE_IDENT;
            ident_len = {4'd0, matched};
            ident_over = 1'b0;
            continue_ident(c, col);
          end
        end
        MODE_IDENT: continue_ident(c, col);
        MODE_NUMBER: begin
          if (is_digit(c)) begin
            number_acc = NumberWidth'(number_acc * NumberWidth'(10))
                         + NumberWidth'(c - "0");
          end else begin
            add_token(KIND_NUMBER, number_acc, '0, '0, '0, 1'b0);
            begin_token(c, col);
          end
        end
        MODE_SLASH: begin
          if (c == "/") begin
            mode = MODE_COMMENT;
          end else begin
            add_plain(KIND_DIVIDE);
            begin_token(c, col);
          end
        end
        MODE_COMMENT: if (c == ChLf) mode = MODE_IDLE;
        default: begin_token(c, col);
      endcase
    endfunction

    function void flush_pending();
      case (mode)
        MODE_KEYWORD: begin
          ident_len = {4'd0, matched};
          ident_over = 1'b0;
          add_ident();
        end
        MODE_IDENT:  add_ident();
        MODE_NUMBER: add_token(KIND_NUMBER, number_acc, '0, '0, '0, 1'b0);
        MODE_SLASH:  add_plain(KIND_DIVIDE);
        default: ;
      endcase
      mode = MODE_IDLE;
    endfunction

    function void note_item(lex_item_t it);
      logic [PosWidth-1:0] col;
      lex_token_t t;
      step_tokens.delete();
      case (it.op)
        OP_CHAR: begin
          col = col_no;
          col_no = col_no + PosWidth'(1);
          feed(it.ch, col);
        end
        OP_EOL: begin
          flush_pending();
          line_no = line_no + PosWidth'(1);
          col_no = '0;
        end
        OP_EOI: begin
          flush_pending();
          add_plain(KIND_EOF);
          line_no = '0;
          col_no = '0;
        end
        default: ;
      endcase
      if (step_tokens.size() > 0) begin
        t = step_tokens.pop_back();
        t.last = 1'b1;
        step_tokens.push_back(t);
      end
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("ERROR: %s", msg);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("token %0d: %s is %0h, expected %0h", tokens_checked, name, got, want));
    endtask

    task check_token(lex_token_t got);
      lex_token_t want;
      tokens_checked++;
      if (expected_tokens.size() == 0) begin
        report($sformatf("token %0d of kind %0d arrived with none expected",
                         tokens_checked, got.token_kind));
        return;
      end
      want = expected_tokens.pop_front();
      compare_field("token_kind", got.token_kind, want.token_kind);
      compare_field("number_value", got.number_value, want.number_value);
      compare_field("ident_line", got.ident_line, want.ident_line);
      compare_field("ident_column", got.ident_column, want.ident_column);
      compare_field("ident_length", got.ident_length, want.ident_length);
      compare_field("ident_too_long", got.ident_too_long, want.ident_too_long);
      compare_field("last", got.last, want.last);
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  lex_item_t  item_i = '0;
  logic       empty;
  logic       pop = 1'b0;
  lex_token_t token_o;

  token_scoreboard sb;
  bit hold_request = 1'b0;
  bit sender_steady = 1'b0;
  int items_sent = 0;
  string symbol_chars = "+-*=(){},:;";

  keyword_lexer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .token_o (token_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Every transfer is seen here, on the values that stood at the clock edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.note_item(item_i);
      if (pop && !empty) sb.check_token(token_o);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] random_letter();
    if ($urandom_range(0, 1)) return 8'("a" + $urandom_range(0, 25));
    return 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) return random_letter();
    if (r < 62) return 8'("0" + $urandom_range(0, 9));
    return "_";
  endfunction

  task automatic send_op(logic [1:0] op, logic [7:0] ch);
    lex_item_t it;
    int gap;
    it.op = op;
    it.ch = ch;
    if (!sender_steady && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_i <= it;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_char(logic [7:0] c);
    send_op(OP_CHAR, c);
  endtask

  // Markers carry a random byte, which the block must ignore.
  task automatic send_marker(logic [1:0] op);
    send_op(op, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_ident(int n);
    send_char(random_letter());
    for (int i = 1; i < n; i++) send_char(random_word_char());
  endtask

  task automatic send_blank();
    case ($urandom_range(0, 3))
      0:       send_char(" ");
      1:       send_char(ChTab);
      2:       send_char(ChCr);
      default: send_char(ChLf);
    endcase
  endtask

  // Stop offering items until every owed token has been transferred.
  task automatic drain_wait();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_lexeme();
    int k;
    int n;
    case ($urandom_range(0, 12))
      0, 1: begin
        k = $urandom_range(0, 2);
        n = sb.keyword_text[k].len();
        if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
        for (int i = 0; i < n; i++) send_char(sb.keyword_text[k][i]);
        if ($urandom_range(0, 2) == 0)
          for (int i = 0; i < $urandom_range(1, 4); i++) send_char(random_word_char());
      end
      2, 3: send_ident(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12));
      4: begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) send_char(8'("0" + $urandom_range(0, 9)));
      end
      5: send_char(symbol_chars[$urandom_range(0, symbol_chars.len() - 1)]);
      6: begin
        send_text("//");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) send_char(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 1)) send_char(ChLf);
        else send_marker(OP_EOL);
      end
      7: begin
        send_char("/");
        if ($urandom_range(0, 1)) send_char(random_word_char());
      end
      8:  send_blank();
      9:  send_marker(OP_EOL);
      10: send_marker(OP_EOI);
      11: send_char(8'($urandom_range(0, 255)));
      default: send_op(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 1)) send_blank();
  endtask

  initial begin : token_sink
    int stall_left;
    int cycle_no;
    stall_left = 0;
    cycle_no = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cycle_no++;
      if (hold_request) begin
        pop <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if ((cycle_no / 256) % 4 != 0 && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int start;
    bit drained;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Keyword prefix without a word boundary, partial keyword at end of line,
    // keyword broken by a symbol, number at end of input, comment ended by a
    // newline byte, lone slash, byte zero and high bytes, unused op, minus.
    send_text("lett");
    send_char(" ");
    send_text("re");
    send_marker(OP_EOL);
    send_text("f+");
    send_text("99");
    send_marker(OP_EOI);
    send_text("//q");
    send_char(ChLf);
    send_text("/A_");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h80);
    send_marker(OpUnused);
    send_char("-");
    send_char(ChTab);
    send_char(ChCr);
    send_marker(OP_EOI);
    drain_wait();

    // The sink holds off while whole keywords keep arriving, so the queue fills.
    hold_request = 1'b1;
    for (int k = 0; k < 3; k++) begin
      send_text(sb.keyword_text[k]);
      send_char(";");
    end

    start = items_sent;
    drained = 1'b0;
    while (items_sent - start < RandomItems) begin
      if ($urandom_range(0, 7) == 0) sender_steady = !sender_steady;
      if (!drained && items_sent - start >= RandomItems / 2) begin
        drain_wait();
        drained = 1'b1;
      end
      random_lexeme();
    end
    sender_steady = 1'b0;
    send_marker(OP_EOI);

    drain_wait();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d tokens never arrived", sb.pending()));
    $display("run: %0d items in, %0d tokens checked, %0d mismatches", items_sent,
             sb.tokens_checked, sb.errors);
    $display("run: keywords and prefixes, comments, symbols, numbers, odd bytes, "
             , "unused op, full-queue stalls and a full drain mid-stream");
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/kl_pkg.sv
sv/kl_front.sv
sv/kl_queue.sv
sv/kl_back.sv
sv/keyword_lexer.sv
tb/sv/tb_keyword_lexer.sv
